// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define LWH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lwh assertion failed");
// next-cycle implication
`define LWH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lwh assertion failed");
`else
`define LWH_ASSERT_IMP(label, ante, cons)
`define LWH_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/lwh_pkg.sv =====
// types, constants and bucketing functions of the latency histogram
`timescale 1ns / 1ps

package lwh_pkg;

	localparam int unsigned SAMPLE_W    = 24;
	localparam int unsigned WLEN_W      = 16;
	localparam int unsigned CNT_W       = 16;
	localparam int unsigned SUM_W       = 40;
	localparam int unsigned AVG_W       = 24;
	localparam int unsigned BKT_W       = 16;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned NUM_LIMITS  = 10;
	localparam int unsigned NBINS       = NUM_LIMITS + 1;
	localparam int unsigned BIN_W       = $clog2(NBINS);
	localparam int unsigned DIV_CNT_W   = $clog2(SUM_W + 1);
	localparam int unsigned OUT_TDATA_W = 3 * SAMPLE_W + BKT_W;

	localparam logic [SAMPLE_W-1:0] MIN_RESET  = SAMPLE_W'(10000000);
	localparam logic [WLEN_W-1:0]   WLEN_RESET = WLEN_W'(1000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_REP_RD,
		ST_REP_OUT,
		ST_BKT_RD,
		ST_BKT_WR
	} lwh_state_t;

	typedef struct packed {
		logic             en;
		logic [BIN_W-1:0] addr;
	} bkt_rd_t;

	typedef struct packed {
		logic             en;
		logic [BIN_W-1:0] addr;
		logic [BKT_W-1:0] data;
	} bkt_wr_t;

	// upper bucket limits; entries past the tenth never match
	function automatic logic [SAMPLE_W-1:0] limit_at(int unsigned i);
		logic [SAMPLE_W-1:0] lim;
		case (i)
			0:       lim = SAMPLE_W'(10);
			1:       lim = SAMPLE_W'(20);
			2:       lim = SAMPLE_W'(30);
			3:       lim = SAMPLE_W'(40);
			4:       lim = SAMPLE_W'(50);
			5:       lim = SAMPLE_W'(100);
			6:       lim = SAMPLE_W'(500);
			7:       lim = SAMPLE_W'(1000);
			8:       lim = SAMPLE_W'(2000);
			9:       lim = SAMPLE_W'(5000);
			default: lim = '0;
		endcase
		return lim;
	endfunction

	// first bucket whose limit lies above the sample, else overflow
	function automatic logic [BIN_W-1:0] bin_of(logic [SAMPLE_W-1:0] v);
		logic [BIN_W-1:0] b;
		b = BIN_W'(NUM_LIMITS);
		for (int i = int'(NUM_LIMITS) - 1; i >= 0; i--) begin
			if (v < limit_at(i)) begin
				b = BIN_W'(i);
			end
		end
		return b;
	endfunction

endpackage

// ===== hdl/latency_window_histogram.sv =====
// latency window histogram top level: control sequencer, window registers, output beat register
// sequence: a sample that closes no window takes the accept, bucket read and bucket write states
// a sample that closes a window takes the accept state, the bit-serial divide of the 40-bit
// sum, a read state and an output state per bucket beat over 11 buckets, then the bucket
// update; output stalls hold the report beats
// throughput: one sample at a time, a new beat is taken only in idle, the 40-step divider and
// the read and output states per bucket in the walk of the bucket memory set the window-end cost
// reset: async active low; window length 1000, sum/count/max cleared, min 10000000, buckets zero
`timescale 1ns / 1ps
`include "assert_macros.svh"

module latency_window_histogram import lwh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: window length
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [WLEN_W-1:0]      cfg_data,
	// sample input
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [SAMPLE_W-1:0]    s_axis_tdata,  // sample_us[23:0]
	// report output
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// window_average[23:0], window_min[47:24], window_max[71:48], bucket_count[87:72]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [IDX_W-1:0]       m_axis_tuser,  // bucket_index[3:0]
	output logic                   m_axis_tlast   // last_of_report
);

	// control state
	lwh_state_t state_q, state_d;

	// configuration and window state
	logic [WLEN_W-1:0]   wlen_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;

	// current sample
	logic [SAMPLE_W-1:0] sample_q;
	logic [BIN_W-1:0]    bin_q;
	logic                pos_q;

	// report sequencing
	logic [AVG_W-1:0]    avg_q;
	logic [BIN_W-1:0]    idx_q;

	// output beat register
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [IDX_W-1:0]       m_user_q;
	logic                   m_last_q;

	// datapath nets
	logic                s_acc;
	logic                report_now;
	logic                out_free;
	logic                idx_last;
	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    div_quo;
	logic [SUM_W:0]      sum_add;
	logic [SAMPLE_W-1:0] in_sample;
	bkt_rd_t             rd_req;
	bkt_wr_t             wr_req;
	logic [BKT_W-1:0]    rd_data;

	assign in_sample  = s_axis_tdata;
	assign s_acc      = s_axis_tvalid && s_axis_tready;
	// a window closes once the count reaches the length, also after the length was shortened
	assign report_now = (count_q >= wlen_q);
	assign out_free   = !m_valid_q || m_axis_tready;
	assign idx_last   = (idx_q == BIN_W'(NUM_LIMITS));
	assign sum_add    = {1'b0, sum_q} + (SUM_W + 1)'(in_sample);
	assign cfg_ready  = 1'b1;

	lwh_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	lwh_bucket_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.wr_req  (wr_req)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_d = report_now ? ST_DIV : ST_BKT_RD;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_REP_RD;
				end
			end
			ST_REP_RD: state_d = ST_REP_OUT;
			ST_REP_OUT: begin
				if (out_free) begin
					state_d = idx_last ? ST_BKT_RD : ST_REP_RD;
				end
			end
			ST_BKT_RD: state_d = ST_BKT_WR;
			ST_BKT_WR: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, divider start, memory requests
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		rd_req        = '0;
		wr_req        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				div_start     = s_axis_tvalid && report_now;
			end
			ST_REP_RD: begin
				rd_req.en   = 1'b1;
				rd_req.addr = idx_q;
			end
			ST_REP_OUT: begin
				// bucket is cleared as its beat is loaded
				wr_req.en   = out_free;
				wr_req.addr = idx_q;
				wr_req.data = '0;
			end
			ST_BKT_RD: begin
				rd_req.en   = 1'b1;
				rd_req.addr = bin_q;
			end
			ST_BKT_WR: begin
				// saturating increment, zero samples leave the buckets alone
				wr_req.en   = pos_q;
				wr_req.addr = bin_q;
				wr_req.data = (rd_data == '1) ? rd_data : rd_data + BKT_W'(1);
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			wlen_q <= cfg_data;
		end
	end

	// window sum, count, min and max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= MIN_RESET;
			max_q   <= '0;
		end else begin
			if (s_acc && !report_now) begin
				sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
				if (count_q != '1) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (state_q == ST_REP_OUT && out_free && idx_last) begin
				sum_q   <= '0;
				count_q <= '0;
				min_q   <= MIN_RESET;
				max_q   <= '0;
			end
			if (state_q == ST_BKT_WR) begin
				if (pos_q && sample_q < min_q) begin
					min_q <= sample_q;
				end
				if (sample_q > max_q) begin
					max_q <= sample_q;
				end
			end
		end
	end

	// sample capture and report index
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sample_q <= in_sample;
			bin_q    <= bin_of(in_sample);
			pos_q    <= (in_sample != '0);
			idx_q    <= '0;
		end else if (state_q == ST_REP_OUT && out_free && !idx_last) begin
			idx_q <= idx_q + BIN_W'(1);
		end
		if (div_done) begin
			// empty window averages to zero, the mean is clamped to 24 bits
			if (count_q == '0) begin
				avg_q <= '0;
			end else if (div_quo[SUM_W-1:AVG_W] != '0) begin
				avg_q <= '1;
			end else begin
				avg_q <= div_quo[AVG_W-1:0];
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_REP_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REP_OUT && out_free) begin
			m_data_q <= {rd_data, max_q, min_q, avg_q};
			m_user_q <= IDX_W'(idx_q);
			m_last_q <= idx_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	// the last beat of a report always carries the overflow bucket
	`LWH_ASSERT_IMP(a_last_is_overflow, m_axis_tvalid && m_axis_tlast, m_axis_tuser == IDX_W'(NUM_LIMITS))
	// the divider only finishes while the sequencer waits for it
	`LWH_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)
	// the running minimum never takes a zero sample
	`LWH_ASSERT_IMP(a_min_positive, 1'b1, min_q != '0)
	// a closing sample always starts the divider
	`LWH_ASSERT_NXT(a_report_starts_div, s_acc && report_now, state_q == ST_DIV)

endmodule

// ===== hdl/lwh_bucket_mem.sv =====
// bucket counter memory, one write and one registered read port, reads zero until written
`timescale 1ns / 1ps

module lwh_bucket_mem import lwh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bkt_rd_t          rd_req,
	output logic [BKT_W-1:0] rd_data,
	input  bkt_wr_t          wr_req
);

	logic [BKT_W-1:0] mem [NBINS];
	logic [NBINS-1:0] valid_q;
	logic [BKT_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_req.en) begin
			valid_q[wr_req.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data_q <= valid_q[rd_req.addr] ? mem[rd_req.addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/lwh_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lwh_divider import lwh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [CNT_W:0]       rem_sh;
	logic [CNT_W+1:0]     diff;

	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(SUM_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== verif/tb.sv =====
// testbench for the latency window histogram: report prediction, random stalls, window changes
`timescale 1ns / 1ps

module tb import lwh_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned RANDOM_ITEMS  = 120;
	localparam int unsigned MAX_SHOWN     = 10;
	localparam int unsigned N_BOUNDARY    = 25;

	// upper limit of each regular bucket, in microseconds
	localparam logic [SAMPLE_W-1:0] BUCKET_BOUND [NUM_LIMITS] =
		'{10, 20, 30, 40, 50, 100, 500, 1000, 2000, 5000};

	// bucket edges from both sides, zero, and all-ones / alternating bit patterns
	localparam logic [SAMPLE_W-1:0] BOUNDARY_SAMPLES [N_BOUNDARY] = '{
		0, 1, 9, 10, 19, 20, 29, 30, 39, 40, 49, 50, 99, 100, 499, 500,
		999, 1000, 1999, 2000, 4999, 5000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};

	// one output beat of a window report
	typedef struct packed {
		logic [AVG_W-1:0]    avg;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [IDX_W-1:0]    bucket;
		logic [BKT_W-1:0]    tally;
		logic                closing;
	} report_beat_t;

	// tracks window state and the report beats still owed by the block
	class latency_report_tracker;
		logic [WLEN_W-1:0]   window_len;
		logic [BKT_W-1:0]    bucket_tally [NBINS];
		logic [CNT_W-1:0]    summed;
		logic [SUM_W-1:0]    total;
		logic [SAMPLE_W-1:0] least;
		logic [SAMPLE_W-1:0] greatest;
		report_beat_t        pending_beats [$];
		int unsigned         mismatches;

		function new();
			window_len = WLEN_RESET;
			mismatches = 0;
			clear_window();
		endfunction

		function void clear_window();
			foreach (bucket_tally[i]) bucket_tally[i] = '0;
			summed   = '0;
			total    = '0;
			least    = MIN_RESET;
			greatest = '0;
		endfunction

		// accepted sample: close the window if full, else sum it, then update min/max/buckets
		function void note_sample(logic [SAMPLE_W-1:0] v);
			report_beat_t     b;
			logic [SUM_W:0]   wide;
			logic [SUM_W-1:0] quot;
			int unsigned      slot;
			if (summed >= window_len) begin
				quot = (summed != '0) ? total / SUM_W'(summed) : '0;
				b.avg = (|quot[SUM_W-1:AVG_W]) ? '1 : quot[AVG_W-1:0];
				b.lo  = least;
				b.hi  = greatest;
				for (int i = 0; i < NBINS; i++) begin
					b.bucket  = IDX_W'(i);
					b.tally   = bucket_tally[i];
					b.closing = (i == NBINS - 1);
					pending_beats.push_back(b);
				end
				clear_window();
			end else begin
				wide  = total + v;
				total = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
				if (summed != '1) summed++;
			end
			if (v != '0 && v < least) least = v;
			if (v > greatest) greatest = v;
			if (v != '0) begin
				slot = NUM_LIMITS;
				for (int i = 0; i < NUM_LIMITS; i++) begin
					if (slot == NUM_LIMITS && v < BUCKET_BOUND[i]) slot = i;
				end
				if (bucket_tally[slot] != '1) bucket_tally[slot]++;
			end
		endfunction

		// accepted output beat against the oldest owed one
		function void check_beat(report_beat_t got);
			report_beat_t want;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected report beat: bucket %0d tally %0d last %0b",
						got.bucket, got.tally, got.closing);
				return;
			end
			want = pending_beats.pop_front();
			if (want.avg != got.avg || want.lo != got.lo || want.hi != got.hi ||
					want.bucket != got.bucket || want.tally != got.tally ||
					want.closing != got.closing) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("report beat mismatch: exp avg %0d min %0d max %0d bucket %0d",
						want.avg, want.lo, want.hi, want.bucket,
						" tally %0d last %0b / got avg %0d min %0d max %0d",
						want.tally, want.closing, got.avg, got.lo, got.hi,
						" bucket %0d tally %0d last %0b",
						got.bucket, got.tally, got.closing);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [WLEN_W-1:0]      cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [SAMPLE_W-1:0]    s_axis_tdata;   // sample_us
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // window_average, window_min, window_max, bucket_count
	logic [IDX_W-1:0]       m_axis_tuser;   // bucket_index
	logic                   m_axis_tlast;

	latency_report_tracker tracker;
	bit                    sender_calm;

	latency_window_histogram dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mix of tiny, mid-range, bucket-edge and full-width latencies
	function automatic logic [SAMPLE_W-1:0] draw_latency();
		int unsigned k;
		case ($urandom_range(0, 7))
			0: return '0;
			1, 2: return SAMPLE_W'($urandom_range(1, 60));
			3: return SAMPLE_W'($urandom_range(1, 6000));
			4: begin
				k = $urandom_range(0, NUM_LIMITS - 1);
				return BUCKET_BOUND[k] - 1 + SAMPLE_W'($urandom_range(0, 1));
			end
			5: return SAMPLE_W'($urandom_range(5000, 200000));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// offer one sample after a random gap; tvalid stays high when the next gap is zero
	task automatic feed_sample(logic [SAMPLE_W-1:0] v);
		int unsigned gap;
		gap = sender_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_sample(v);
	endtask

	// drop tvalid, wait for every owed beat, then let the bucket update finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// window length write, only issued while the block is idle
	task automatic write_window(logic [WLEN_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.window_len = len;
	endtask

	// report beat sink: random backpressure, one long hold early on
	initial begin : report_sink
		report_beat_t got;
		int unsigned  gap;
		int unsigned  beats_seen;
		bit           calm;
		m_axis_tready <= 1'b0;
		beats_seen = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.avg     = m_axis_tdata[AVG_W-1:0];
				got.lo      = m_axis_tdata[AVG_W +: SAMPLE_W];
				got.hi      = m_axis_tdata[AVG_W + SAMPLE_W +: SAMPLE_W];
				got.tally   = m_axis_tdata[AVG_W + 2 * SAMPLE_W +: BKT_W];
				got.bucket  = m_axis_tuser;
				got.closing = m_axis_tlast;
				tracker.check_beat(got);
				beats_seen++;
				// alternate between stretches with and without stalls
				if (beats_seen % 40 == 0) calm = !calm;
				// long hold mid-report while samples keep coming, so the input backs up
				if (beats_seen == 5)
					gap = LONG_HOLD;
				else
					gap = calm ? 0 : $urandom_range(0, 16);
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_fed;
		int unsigned n;
		tracker = new();
		sender_calm = 1'b0;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bucket edges under the reset window of 1000, so nothing is reported yet
		for (int i = 0; i < N_BOUNDARY; i++) feed_sample(BOUNDARY_SAMPLES[i]);
		settle();

		// window shortened below the count already summed: the next sample closes it
		write_window(16'd1);
		// then a window of zeros only: empty min, zero max and average
		repeat (3) feed_sample('0);
		random_fed = 0;
		repeat (20) begin
			feed_sample(draw_latency());
			random_fed++;
		end
		settle();

		// random phases with short windows so reports come often
		while (random_fed < RANDOM_ITEMS) begin
			write_window(($urandom_range(0, 4) == 0) ? WLEN_W'(1) :
				WLEN_W'($urandom_range(2, 12)));
			sender_calm = ($urandom_range(0, 3) == 0);
			n = $urandom_range(8, 30);
			repeat (n) feed_sample(draw_latency());
			random_fed += n;
			settle();
		end

		// largest window, then cut short to force out a report with huge samples
		sender_calm = 1'b0;
		write_window('1);
		feed_sample(24'hFFFFFF);
		repeat (5) feed_sample(draw_latency());
		settle();
		write_window(16'd3);
		feed_sample(draw_latency());
		feed_sample(24'hFFFFFF);
		settle();

		if (tracker.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== latency_window_histogram.f =====
+incdir+hdl
hdl/lwh_pkg.sv
hdl/lwh_bucket_mem.sv
hdl/lwh_divider.sv
hdl/latency_window_histogram.sv
verif/tb.sv
